// ===== rtl/tlmc_pkg.sv =====
// Types, codes and lamp helpers for the traffic light mode controller.
// No dependencies; used by traffic_light_mode_controller_core.
package tlmc_pkg;

	localparam int unsigned LevelW = 8;
	localparam int unsigned SampleW = 10;
	localparam int unsigned CfgDataW = 16;
	localparam int unsigned CfgIndexW = 3;

	localparam logic [LevelW-1:0] LevelFull = 8'd255;
	localparam logic [9:0] SinceMax = 10'd1023;
	localparam logic [11:0] BlinkMax = 12'd4095;
	localparam logic [15:0] PhaseMax = 16'd65535;
	localparam logic [10:0] Div1023 = 11'd1023;

	typedef enum logic [2:0] {
		OP_TICK      = 3'd0,
		OP_EMERG_BTN = 3'd1,
		OP_OFF_BTN   = 3'd2,
		OP_BLINK_BTN = 3'd3,
		OP_MODE_CMD  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		REQ_OFF    = 2'd0,
		REQ_BLINK  = 2'd1,
		REQ_NORMAL = 2'd2,
		REQ_EMERG  = 2'd3
	} mode_req_t;

	typedef enum logic [1:0] {
		SHOWN_NORMAL = 2'd0,
		SHOWN_EMERG  = 2'd1,
		SHOWN_BLINK  = 2'd2,
		SHOWN_OFF    = 2'd3
	} mode_shown_t;

	typedef enum logic [2:0] {
		PH_RED   = 3'd0,
		PH_YEL1  = 3'd1,
		PH_GREEN = 3'd2,
		PH_FLASH = 3'd3,
		PH_YEL2  = 3'd4,
		PH_STOP  = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		CFG_RED_MS        = 3'd0,
		CFG_YELLOW_MS     = 3'd1,
		CFG_GREEN_MS      = 3'd2,
		CFG_FLASH_STEP_MS = 3'd3,
		CFG_FLASH_STEPS   = 3'd4,
		CFG_BLINK_HALF_MS = 3'd5,
		CFG_DEBOUNCE_MS   = 3'd6
	} cfg_index_t;

	typedef struct packed {
		logic [LevelW-1:0] green;
		logic [LevelW-1:0] yellow;
		logic [LevelW-1:0] red;
	} lamps_t;

	// floor(sample*255/1023): divide by 1023 as x/1024 plus one correction
	function automatic logic [LevelW-1:0] sample_to_level(input logic [SampleW-1:0] s);
		logic [17:0] prod;
		logic [7:0]  q0;
		logic [10:0] rsum;
		prod = {s, 8'b0} - {8'b0, s};
		q0 = prod[17:10];
		rsum = {1'b0, prod[9:0]} + {3'b0, q0};
		sample_to_level = q0 + {7'b0, (rsum >= Div1023)};
	endfunction

	function automatic lamps_t blink_lamps(input logic on, input logic [LevelW-1:0] lvl);
		logic [LevelW-1:0] v;
		v = on ? lvl : '0;
		blink_lamps = '{green: v, yellow: v, red: v};
	endfunction

	function automatic lamps_t normal_lamps(input phase_t ph, input logic on,
			input logic [LevelW-1:0] lvl, input lamps_t old);
		normal_lamps = old;
		unique case (ph)
			PH_RED: normal_lamps = '{green: '0, yellow: '0, red: lvl};
			PH_YEL1, PH_YEL2: normal_lamps = '{green: '0, yellow: lvl, red: '0};
			PH_GREEN: normal_lamps = '{green: lvl, yellow: '0, red: '0};
			PH_FLASH: normal_lamps = '{green: (on ? lvl : '0), yellow: '0, red: '0};
			default: normal_lamps = old;
		endcase
	endfunction

endpackage

// ===== rtl/traffic_light_mode_controller_core.sv =====
// Traffic light mode controller: normal light cycle, emergency, off and blink modes.
// Depends on tlmc_pkg for codes, lamp types and the level conversion.
//
// Each accepted word yields one result word: the pot sample is converted
// to a level and registered in the input stage, then the whole mode/phase
// state update is done from that stage and registered into the result
// stage. Sustained rate is one word per cycle while out_ready holds; the
// result register lets one more word in while a result waits. Configuration
// writes through cfg_wen/cfg_index/cfg_data take effect on the next clock.
module traffic_light_mode_controller_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  logic [tlmc_pkg::CfgIndexW-1:0]   cfg_index,
	input  logic [tlmc_pkg::CfgDataW-1:0]    cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [2:0]                       operation,
	input  logic [9:0]                       pot_sample,
	input  logic [1:0]                       mode_request,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [7:0]                       red_level,
	output logic [7:0]                       yellow_level,
	output logic [7:0]                       green_level,
	output logic [1:0]                       mode_shown,
	output logic [2:0]                       cycle_phase
);

	// configuration
	logic [15:0] red_ms_q, yellow_ms_q, green_ms_q;
	logic [9:0]  flash_step_ms_q;
	logic [3:0]  flash_steps_q;
	logic [11:0] blink_half_ms_q;
	logic [9:0]  debounce_ms_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_ms_q        <= 16'd2000;
			yellow_ms_q     <= 16'd500;
			green_ms_q      <= 16'd2000;
			flash_step_ms_q <= 10'd167;
			flash_steps_q   <= 4'd6;
			blink_half_ms_q <= 12'd500;
			debounce_ms_q   <= 10'd200;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				tlmc_pkg::CFG_RED_MS:        red_ms_q        <= cfg_data;
				tlmc_pkg::CFG_YELLOW_MS:     yellow_ms_q     <= cfg_data;
				tlmc_pkg::CFG_GREEN_MS:      green_ms_q      <= cfg_data;
				tlmc_pkg::CFG_FLASH_STEP_MS: flash_step_ms_q <= cfg_data[9:0];
				tlmc_pkg::CFG_FLASH_STEPS:   flash_steps_q   <= cfg_data[3:0];
				tlmc_pkg::CFG_BLINK_HALF_MS: blink_half_ms_q <= cfg_data[11:0];
				tlmc_pkg::CFG_DEBOUNCE_MS:   debounce_ms_q   <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// input stage
	logic       valid_s1;
	logic [2:0] op_s1;
	logic [1:0] req_s1;
	logic [7:0] level_s1;
	logic       advance;

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1    <= operation;
			req_s1   <= mode_request;
			level_s1 <= tlmc_pkg::sample_to_level(pot_sample);
		end
	end

	// controller state
	tlmc_pkg::phase_t phase_q, phase_d;
	logic [15:0]      phase_elapsed_q, phase_elapsed_d;
	logic [3:0]       flash_count_q, flash_count_d;
	logic             blink_on_q, blink_on_d;
	logic             emerg_q, emerg_d;
	logic             off_q, off_d;
	logic             blink_q, blink_d;
	logic [11:0]      blink_elapsed_q, blink_elapsed_d;
	logic [9:0]       since_press_q, since_press_d;
	logic [7:0]       level_q, level_d;
	tlmc_pkg::lamps_t lamps_q, lamps_d;
	logic             enter;

	always_comb begin
		phase_d         = phase_q;
		phase_elapsed_d = phase_elapsed_q;
		flash_count_d   = flash_count_q;
		blink_on_d      = blink_on_q;
		emerg_d         = emerg_q;
		off_d           = off_q;
		blink_d         = blink_q;
		blink_elapsed_d = blink_elapsed_q;
		since_press_d   = since_press_q;
		level_d         = level_q;
		lamps_d         = lamps_q;
		enter           = 1'b0;

		unique case (op_s1)
			tlmc_pkg::OP_TICK: begin
				if (since_press_q != tlmc_pkg::SinceMax)
					since_press_d = since_press_q + 10'd1;
				level_d = level_s1;
				if (emerg_q || (!blink_q && off_q)) begin
					// lamps frozen
				end else if (blink_q) begin
					if (blink_elapsed_q != tlmc_pkg::BlinkMax)
						blink_elapsed_d = blink_elapsed_q + 12'd1;
					if (blink_elapsed_d >= blink_half_ms_q) begin
						blink_elapsed_d = '0;
						blink_on_d      = !blink_on_q;
						lamps_d         = tlmc_pkg::blink_lamps(blink_on_d, level_d);
					end
				end else begin
					if (phase_elapsed_q != tlmc_pkg::PhaseMax)
						phase_elapsed_d = phase_elapsed_q + 16'd1;
					unique case (phase_q)
						tlmc_pkg::PH_RED: begin
							if (phase_elapsed_d >= red_ms_q) begin
								phase_d = tlmc_pkg::PH_YEL1;
								phase_elapsed_d = '0;
							end
						end
						tlmc_pkg::PH_YEL1: begin
							if (phase_elapsed_d >= yellow_ms_q) begin
								phase_d = tlmc_pkg::PH_GREEN;
								phase_elapsed_d = '0;
							end
						end
						tlmc_pkg::PH_GREEN: begin
							if (phase_elapsed_d >= green_ms_q) begin
								phase_d = tlmc_pkg::PH_FLASH;
								phase_elapsed_d = '0;
								flash_count_d = '0;
							end
						end
						tlmc_pkg::PH_FLASH: begin
							if (phase_elapsed_d >= {6'b0, flash_step_ms_q}) begin
								phase_elapsed_d = '0;
								blink_on_d      = !blink_on_q;
								flash_count_d   = flash_count_q + 4'd1;
								if (flash_count_d >= flash_steps_q) begin
									phase_d = tlmc_pkg::PH_YEL2;
									flash_count_d = '0;
								end
							end
						end
						tlmc_pkg::PH_YEL2: begin
							if (phase_elapsed_d >= yellow_ms_q) begin
								phase_d = tlmc_pkg::PH_RED;
								phase_elapsed_d = '0;
							end
						end
						default: begin
							phase_d = tlmc_pkg::PH_RED;
							phase_elapsed_d = '0;
						end
					endcase
					lamps_d = tlmc_pkg::normal_lamps(phase_d, blink_on_d, level_d, lamps_q);
				end
			end
			tlmc_pkg::OP_EMERG_BTN, tlmc_pkg::OP_OFF_BTN, tlmc_pkg::OP_BLINK_BTN: begin
				if (since_press_q >= debounce_ms_q) begin
					since_press_d = '0;
					enter = 1'b1;
					priority case (op_s1)
						tlmc_pkg::OP_EMERG_BTN: emerg_d = !emerg_q;
						tlmc_pkg::OP_OFF_BTN:   off_d = !off_q;
						default: begin
							blink_d = !blink_q;
							if (blink_d) begin
								blink_elapsed_d = '0;
								blink_on_d = 1'b1;
							end
						end
					endcase
				end
			end
			tlmc_pkg::OP_MODE_CMD: begin
				enter   = 1'b1;
				emerg_d = 1'b0;
				off_d   = 1'b0;
				blink_d = 1'b0;
				unique case (req_s1)
					tlmc_pkg::REQ_OFF: off_d = 1'b1;
					tlmc_pkg::REQ_BLINK: begin
						blink_d = 1'b1;
						blink_elapsed_d = '0;
						blink_on_d = 1'b1;
					end
					tlmc_pkg::REQ_NORMAL: phase_d = tlmc_pkg::PH_STOP;
					default: emerg_d = 1'b1;
				endcase
			end
			default: ;
		endcase

		// apply top-priority mode after a flag change
		if (enter) begin
			priority if (emerg_d) begin
				phase_d = tlmc_pkg::PH_STOP;
				lamps_d = '{green: '0, yellow: '0, red: tlmc_pkg::LevelFull};
			end else if (blink_d) begin
				phase_d = tlmc_pkg::PH_STOP;
				lamps_d = tlmc_pkg::blink_lamps(blink_on_d, level_d);
			end else if (off_d) begin
				phase_d = tlmc_pkg::PH_STOP;
				lamps_d = '0;
			end else if (phase_d == tlmc_pkg::PH_STOP) begin
				phase_d = tlmc_pkg::PH_RED;
				phase_elapsed_d = '0;
				flash_count_d = '0;
				lamps_d = tlmc_pkg::normal_lamps(phase_d, blink_on_d, level_d, lamps_d);
			end else begin
				// cycle continues untouched
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= tlmc_pkg::PH_RED;
			phase_elapsed_q <= '0;
			flash_count_q   <= '0;
			blink_on_q      <= 1'b0;
			emerg_q         <= 1'b0;
			off_q           <= 1'b0;
			blink_q         <= 1'b0;
			blink_elapsed_q <= '0;
			since_press_q   <= '0;
			level_q         <= '0;
			lamps_q         <= '0;
		end else if (advance) begin
			phase_q         <= phase_d;
			phase_elapsed_q <= phase_elapsed_d;
			flash_count_q   <= flash_count_d;
			blink_on_q      <= blink_on_d;
			emerg_q         <= emerg_d;
			off_q           <= off_d;
			blink_q         <= blink_d;
			blink_elapsed_q <= blink_elapsed_d;
			since_press_q   <= since_press_d;
			level_q         <= level_d;
			lamps_q         <= lamps_d;
		end
	end

	// result register
	tlmc_pkg::mode_shown_t shown_d;

	always_comb begin
		priority if (emerg_d) shown_d = tlmc_pkg::SHOWN_EMERG;
		else if (blink_d)     shown_d = tlmc_pkg::SHOWN_BLINK;
		else if (off_d)       shown_d = tlmc_pkg::SHOWN_OFF;
		else                  shown_d = tlmc_pkg::SHOWN_NORMAL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			red_level    <= lamps_d.red;
			yellow_level <= lamps_d.yellow;
			green_level  <= lamps_d.green;
			mode_shown   <= shown_d;
			cycle_phase  <= phase_d;
		end
	end

	// checks
	a_emerg_lamps: assert property (@(posedge clk) disable iff (!arst_n)
		emerg_q |-> (lamps_q.red == tlmc_pkg::LevelFull) && (lamps_q.yellow == '0)
			&& (lamps_q.green == '0))
		else $error("emergency without full red");

	a_stop_iff_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(emerg_q || off_q || blink_q) == (phase_q == tlmc_pkg::PH_STOP))
		else $error("stop phase disagrees with mode flags");

	a_off_dark: assert property (@(posedge clk) disable iff (!arst_n)
		(off_q && !blink_q && !emerg_q) |-> (lamps_q == '0))
		else $error("off mode with lamps lit");

	a_flash_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != tlmc_pkg::PH_FLASH && phase_q != tlmc_pkg::PH_STOP)
			|-> (flash_count_q == '0))
		else $error("flash count left over outside flash");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("result lost after state update");

endmodule

// ===== bench/traffic_light_mode_controller_core_tb.sv =====
// Testbench for traffic_light_mode_controller_core: random and directed words, lamp prediction.
// Needs tlmc_pkg and the core; self-checking, reports pass or fail at the end.
`timescale 1ns / 100ps

module traffic_light_mode_controller_core_tb;

	localparam int unsigned QuietLimit = 1000;

	typedef struct {
		logic [2:0] op;
		logic [9:0] sample;
		logic [1:0] req;
	} light_word_t;

	typedef struct {
		logic [7:0] red;
		logic [7:0] yellow;
		logic [7:0] green;
		logic [1:0] shown;
		logic [2:0] phase;
	} lamp_result_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [tlmc_pkg::CfgIndexW-1:0] cfg_index = '0;
	logic [tlmc_pkg::CfgDataW-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] operation = '0;
	logic [9:0] pot_sample = '0;
	logic [1:0] mode_request = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] red_level, yellow_level, green_level;
	logic [1:0] mode_shown;
	logic [2:0] cycle_phase;

	light_word_t pending_words[$];
	lamp_result_t lamps_due[$];
	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;
	logic in_taken = 1'b0;
	logic out_taken = 1'b0;
	int unsigned in_gap = 0, out_gap = 0;
	bit in_calm = 1'b0, out_calm = 1'b0;

	// predicted settings
	int unsigned red_len, yellow_len, green_len, step_len, step_count, blink_half, debounce_len;

	// predicted controller state
	tlmc_pkg::phase_t cyc_phase;
	logic [15:0] phase_ms;
	logic [3:0] flash_done;
	logic blink_lit, emerg_on, dark_on, blink_mode;
	logic [11:0] blink_ms;
	logic [9:0] since_press;
	logic [7:0] level, lamp_r, lamp_y, lamp_g;

	traffic_light_mode_controller_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.pot_sample(pot_sample),
		.mode_request(mode_request),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.red_level(red_level),
		.yellow_level(yellow_level),
		.green_level(green_level),
		.mode_shown(mode_shown),
		.cycle_phase(cycle_phase)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int unsigned pick_gap(bit calm);
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic show_cycle();
		case (cyc_phase)
			tlmc_pkg::PH_RED: begin
				lamp_r = level; lamp_y = '0; lamp_g = '0;
			end
			tlmc_pkg::PH_YEL1, tlmc_pkg::PH_YEL2: begin
				lamp_r = '0; lamp_y = level; lamp_g = '0;
			end
			tlmc_pkg::PH_GREEN: begin
				lamp_r = '0; lamp_y = '0; lamp_g = level;
			end
			tlmc_pkg::PH_FLASH: begin
				lamp_r = '0; lamp_y = '0; lamp_g = blink_lit ? level : '0;
			end
			default: ;
		endcase
	endtask

	task automatic show_blink();
		lamp_r = blink_lit ? level : '0;
		lamp_y = lamp_r;
		lamp_g = lamp_r;
	endtask

	// emergency over blinking over off; no flag left restarts red from the stop phase
	task automatic settle_mode();
		if (emerg_on) begin
			cyc_phase = tlmc_pkg::PH_STOP;
			lamp_r = tlmc_pkg::LevelFull; lamp_y = '0; lamp_g = '0;
		end else if (blink_mode) begin
			cyc_phase = tlmc_pkg::PH_STOP;
			show_blink();
		end else if (dark_on) begin
			cyc_phase = tlmc_pkg::PH_STOP;
			lamp_r = '0; lamp_y = '0; lamp_g = '0;
		end else if (cyc_phase == tlmc_pkg::PH_STOP) begin
			cyc_phase = tlmc_pkg::PH_RED;
			phase_ms = '0;
			flash_done = '0;
			show_cycle();
		end
	endtask

	task automatic advance_lights(logic [2:0] op, logic [9:0] sample, logic [1:0] req);
		int unsigned s;
		lamp_result_t res;
		case (op)
			tlmc_pkg::OP_TICK: begin
				if (since_press < 10'd1023)
					since_press++;
				s = sample;
				level = 8'(s * 255 / 1023);
				if (emerg_on || (!blink_mode && dark_on)) begin
				end else if (blink_mode) begin
					if (blink_ms < 12'd4095)
						blink_ms++;
					if (blink_ms >= blink_half) begin
						blink_ms = '0;
						blink_lit = !blink_lit;
						show_blink();
					end
				end else begin
					if (phase_ms < 16'd65535)
						phase_ms++;
					case (cyc_phase)
						tlmc_pkg::PH_RED: if (phase_ms >= red_len) begin
							cyc_phase = tlmc_pkg::PH_YEL1; phase_ms = '0;
						end
						tlmc_pkg::PH_YEL1: if (phase_ms >= yellow_len) begin
							cyc_phase = tlmc_pkg::PH_GREEN; phase_ms = '0;
						end
						tlmc_pkg::PH_GREEN: if (phase_ms >= green_len) begin
							cyc_phase = tlmc_pkg::PH_FLASH; phase_ms = '0; flash_done = '0;
						end
						tlmc_pkg::PH_FLASH: if (phase_ms >= step_len) begin
							phase_ms = '0;
							blink_lit = !blink_lit;
							flash_done++;
							if (flash_done >= step_count) begin
								cyc_phase = tlmc_pkg::PH_YEL2; flash_done = '0;
							end
						end
						tlmc_pkg::PH_YEL2: if (phase_ms >= yellow_len) begin
							cyc_phase = tlmc_pkg::PH_RED; phase_ms = '0;
						end
						default: begin
							cyc_phase = tlmc_pkg::PH_RED; phase_ms = '0;
						end
					endcase
					show_cycle();
				end
			end
			tlmc_pkg::OP_EMERG_BTN, tlmc_pkg::OP_OFF_BTN, tlmc_pkg::OP_BLINK_BTN:
				if (since_press >= debounce_len) begin
					since_press = '0;
					if (op == tlmc_pkg::OP_EMERG_BTN)
						emerg_on = !emerg_on;
					else if (op == tlmc_pkg::OP_OFF_BTN)
						dark_on = !dark_on;
					else begin
						blink_mode = !blink_mode;
						if (blink_mode) begin
							blink_ms = '0; blink_lit = 1'b1;
						end
					end
					settle_mode();
				end
			tlmc_pkg::OP_MODE_CMD: begin
				emerg_on = 1'b0; dark_on = 1'b0; blink_mode = 1'b0;
				case (req)
					tlmc_pkg::REQ_OFF: dark_on = 1'b1;
					tlmc_pkg::REQ_BLINK: begin
						blink_mode = 1'b1; blink_ms = '0; blink_lit = 1'b1;
					end
					tlmc_pkg::REQ_NORMAL: cyc_phase = tlmc_pkg::PH_STOP;
					default: emerg_on = 1'b1;
				endcase
				settle_mode();
			end
			default: ;
		endcase
		res.red = lamp_r;
		res.yellow = lamp_y;
		res.green = lamp_g;
		res.shown = emerg_on ? tlmc_pkg::SHOWN_EMERG : blink_mode ? tlmc_pkg::SHOWN_BLINK :
			dark_on ? tlmc_pkg::SHOWN_OFF : tlmc_pkg::SHOWN_NORMAL;
		res.phase = cyc_phase;
		lamps_due.push_back(res);
	endtask

	task automatic queue_word(logic [2:0] op, logic [9:0] sample, logic [1:0] req);
		light_word_t w;
		w.op = op;
		w.sample = sample;
		w.req = req;
		pending_words.push_back(w);
	endtask

	task automatic queue_random(int unsigned n, int unsigned tick_pct);
		logic [2:0] op;
		logic [9:0] sample;
		int unsigned r;
		repeat (n) begin
			if ($urandom_range(0, 99) < tick_pct)
				op = tlmc_pkg::OP_TICK;
			else begin
				r = $urandom_range(0, 9);
				if (r < 2)
					op = tlmc_pkg::OP_EMERG_BTN;
				else if (r < 4)
					op = tlmc_pkg::OP_OFF_BTN;
				else if (r < 6)
					op = tlmc_pkg::OP_BLINK_BTN;
				else if (r < 9)
					op = tlmc_pkg::OP_MODE_CMD;
				else
					op = 3'($urandom_range(5, 7));
			end
			r = $urandom_range(0, 9);
			sample = (r == 0) ? 10'd0 : (r == 1) ? 10'd1023 : 10'($urandom_range(0, 1023));
			queue_word(op, sample, 2'($urandom));
		end
	endtask

	task automatic write_reg(tlmc_pkg::cfg_index_t idx, int unsigned val);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[tlmc_pkg::CfgDataW-1:0];
		case (idx)
			tlmc_pkg::CFG_RED_MS: red_len = val & 16'hFFFF;
			tlmc_pkg::CFG_YELLOW_MS: yellow_len = val & 16'hFFFF;
			tlmc_pkg::CFG_GREEN_MS: green_len = val & 16'hFFFF;
			tlmc_pkg::CFG_FLASH_STEP_MS: step_len = val & 10'h3FF;
			tlmc_pkg::CFG_FLASH_STEPS: step_count = val & 4'hF;
			tlmc_pkg::CFG_BLINK_HALF_MS: blink_half = val & 12'hFFF;
			default: debounce_len = val & 10'h3FF;
		endcase
	endtask

	task automatic load_settings(int unsigned r, int unsigned y, int unsigned g,
			int unsigned fs, int unsigned fn, int unsigned bh, int unsigned db);
		write_reg(tlmc_pkg::CFG_RED_MS, r);
		write_reg(tlmc_pkg::CFG_YELLOW_MS, y);
		write_reg(tlmc_pkg::CFG_GREEN_MS, g);
		write_reg(tlmc_pkg::CFG_FLASH_STEP_MS, fs);
		write_reg(tlmc_pkg::CFG_FLASH_STEPS, fn);
		write_reg(tlmc_pkg::CFG_BLINK_HALF_MS, bh);
		write_reg(tlmc_pkg::CFG_DEBOUNCE_MS, db);
		@(negedge clk);
		cfg_wen <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		do begin
			@(negedge clk);
			#1;
		end while (pending_words.size() != 0 || in_valid || lamps_due.size() != 0);
	endtask

	// word driver
	always @(negedge clk) begin : drive_words
		light_word_t w;
		if (arst_n && (!in_valid || in_taken)) begin
			if (in_gap > 0) begin
				in_valid <= 1'b0;
				in_gap--;
			end else if (pending_words.size() > 0) begin
				w = pending_words.pop_front();
				operation <= w.op;
				pot_sample <= w.sample;
				mode_request <= w.req;
				in_valid <= 1'b1;
				if ($urandom_range(0, 59) == 0)
					in_calm = !in_calm;
				in_gap = pick_gap(in_calm);
			end else
				in_valid <= 1'b0;
		end
	end

	// result receiver stalls
	always @(negedge clk) begin
		if (out_taken) begin
			if ($urandom_range(0, 59) == 0)
				out_calm = !out_calm;
			out_gap = pick_gap(out_calm);
		end
		if (out_gap > 0) begin
			out_ready <= 1'b0;
			out_gap--;
		end else
			out_ready <= 1'b1;
	end

	always @(posedge clk) begin : check_results
		lamp_result_t want;
		in_taken <= in_valid && in_ready;
		out_taken <= out_valid && out_ready;
		if (in_valid && in_ready)
			advance_lights(operation, pot_sample, mode_request);
		if (out_valid && out_ready) begin
			if (lamps_due.size() == 0) begin
				$error("result word with none expected");
				mismatches++;
			end else begin
				want = lamps_due.pop_front();
				if (red_level !== want.red) begin
					$error("red_level: expected %0d, got %0d", want.red, red_level);
					mismatches++;
				end
				if (yellow_level !== want.yellow) begin
					$error("yellow_level: expected %0d, got %0d", want.yellow, yellow_level);
					mismatches++;
				end
				if (green_level !== want.green) begin
					$error("green_level: expected %0d, got %0d", want.green, green_level);
					mismatches++;
				end
				if (mode_shown !== want.shown) begin
					$error("mode_shown: expected %0d, got %0d", want.shown, mode_shown);
					mismatches++;
				end
				if (cycle_phase !== want.phase) begin
					$error("cycle_phase: expected %0d, got %0d", want.phase, cycle_phase);
					mismatches++;
				end
			end
		end
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QuietLimit) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		red_len = 2000; yellow_len = 500; green_len = 2000;
		step_len = 167; step_count = 6; blink_half = 500; debounce_len = 200;
		cyc_phase = tlmc_pkg::PH_RED; phase_ms = '0; flash_done = '0; blink_lit = 1'b0;
		emerg_on = 1'b0; dark_on = 1'b0; blink_mode = 1'b0;
		blink_ms = '0; since_press = '0; level = '0;
		lamp_r = '0; lamp_y = '0; lamp_g = '0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings; presses fall in the debounce window after reset
		queue_word(tlmc_pkg::OP_TICK, 10'd0, tlmc_pkg::REQ_OFF);
		queue_word(tlmc_pkg::OP_TICK, 10'd1023, tlmc_pkg::REQ_EMERG);
		queue_word(tlmc_pkg::OP_TICK, 10'd1, tlmc_pkg::REQ_BLINK);
		queue_word(tlmc_pkg::OP_EMERG_BTN, 10'd512, tlmc_pkg::REQ_NORMAL);
		queue_word(tlmc_pkg::OP_OFF_BTN, 10'd0, tlmc_pkg::REQ_OFF);
		queue_word(tlmc_pkg::OP_BLINK_BTN, 10'd0, tlmc_pkg::REQ_OFF);
		queue_word(3'd5, 10'd1022, tlmc_pkg::REQ_EMERG);
		queue_word(3'd6, 10'd0, tlmc_pkg::REQ_OFF);
		queue_word(3'd7, 10'd0, tlmc_pkg::REQ_OFF);
		queue_word(tlmc_pkg::OP_MODE_CMD, 10'd0, tlmc_pkg::REQ_EMERG);
		queue_word(tlmc_pkg::OP_MODE_CMD, 10'd0, tlmc_pkg::REQ_OFF);
		queue_word(tlmc_pkg::OP_MODE_CMD, 10'd0, tlmc_pkg::REQ_BLINK);
		queue_word(tlmc_pkg::OP_TICK, 10'd1023, tlmc_pkg::REQ_OFF);
		queue_word(tlmc_pkg::OP_MODE_CMD, 10'd0, tlmc_pkg::REQ_NORMAL);
		queue_word(tlmc_pkg::OP_MODE_CMD, 10'd0, tlmc_pkg::REQ_NORMAL);
		queue_word(tlmc_pkg::OP_TICK, 10'd512, tlmc_pkg::REQ_OFF);
		drain();

		// short cycle, no debounce: stack the button flags
		load_settings(3, 2, 3, 2, 3, 3, 0);
		queue_word(tlmc_pkg::OP_EMERG_BTN, 10'd0, tlmc_pkg::REQ_OFF);
		queue_word(tlmc_pkg::OP_OFF_BTN, 10'd0, tlmc_pkg::REQ_OFF);
		queue_word(tlmc_pkg::OP_EMERG_BTN, 10'd0, tlmc_pkg::REQ_OFF);
		queue_word(tlmc_pkg::OP_BLINK_BTN, 10'd0, tlmc_pkg::REQ_OFF);
		queue_word(tlmc_pkg::OP_TICK, 10'd1023, tlmc_pkg::REQ_OFF);
		queue_word(tlmc_pkg::OP_TICK, 10'd1023, tlmc_pkg::REQ_OFF);
		queue_word(tlmc_pkg::OP_TICK, 10'd1023, tlmc_pkg::REQ_OFF);
		queue_word(tlmc_pkg::OP_BLINK_BTN, 10'd0, tlmc_pkg::REQ_OFF);
		queue_word(tlmc_pkg::OP_OFF_BTN, 10'd0, tlmc_pkg::REQ_OFF);
		queue_random(100, 75);
		drain();

		// zero registers act as one
		load_settings(0, 0, 0, 0, 0, 0, 0);
		queue_random(80, 70);
		drain();

		load_settings(1, 1, 1, 1, 1, 1, 0);
		queue_random(80, 75);
		drain();

		// widest registers; presses held off by the widest window
		load_settings(65535, 65535, 65535, 1023, 15, 4095, 1023);
		queue_random(380, 97);
		drain();

		repeat (5) begin
			load_settings($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 6),
				$urandom_range(1, 4), $urandom_range(1, 15), $urandom_range(1, 6),
				$urandom_range(0, 8));
			queue_random(50, 80);
			drain();
		end

		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
